FILE: sv/thbf_pkg.sv
`default_nettype none

package thbf_pkg;

  localparam int FUNC_W     = 2;
  localparam int HASH_W     = 64;
  localparam int SIZE_W     = 17;
  localparam int POS_W      = 16;
  localparam int ROW_W      = 8;
  localparam int COL_W      = POS_W - ROW_W;
  localparam int ROWS       = 1 << ROW_W;
  localparam int COLS       = 1 << COL_W;
  localparam int CNT_W      = $clog2(HASH_W);
  localparam int S_TDATA_W  = 2 * HASH_W;
  localparam int S_TUSER_W  = 8;
  localparam int M_TDATA_W  = 8;

  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(1 << POS_W);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1 << POS_W);

  localparam logic [FUNC_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [POS_W-1:0]   pos_a;
    logic [POS_W-1:0]   pos_b;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/thbf_mod.sv
`default_nettype none

module thbf_mod
  import thbf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [HASH_W-1:0] dividend,
  input  wire logic [SIZE_W-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic [POS_W-1:0]       rem
);

  logic [HASH_W-1:0] dvd;
  logic [SIZE_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic [SIZE_W-1:0] shifted;
  logic [SIZE_W-1:0] diff;

  assign shifted = {rem, dvd[HASH_W-1]};
  assign diff    = shifted - dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(HASH_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(HASH_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[HASH_W-2:0], 1'b0};
      if (shifted >= dsr) begin
        rem <= diff[POS_W-1:0];
      end else begin
        rem <= shifted[POS_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, rem} < dsr))
    else $error("remainder not below divisor");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while still busy");
`endif

endmodule

`default_nettype wire

FILE: sv/thbf_front.sv
`default_nettype none

module thbf_front
  import thbf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [HASH_W-1:0]    in_hash_low,
  input  wire logic [HASH_W-1:0]    in_hash_high,
  input  wire logic [SIZE_W-1:0]    size_cfg,
  output logic                      push,
  output cmd_t                      push_cmd,
  input  wire logic                 queue_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t      state;
  cmd_kind_t         kind_in;
  cmd_kind_t         kind;
  logic [POS_W-1:0]  pos_a;
  logic [POS_W-1:0]  pos_b;
  logic [SIZE_W-1:0] size_used;
  logic              accept;
  logic              start;
  logic              busy_a, busy_b;
  logic              done_a, done_b;
  logic [POS_W-1:0]  rem_a, rem_b;

  assign size_used = (size_cfg > SIZE_MAX) ? SIZE_MAX : size_cfg;
  assign in_ready  = (state == F_IDLE);
  assign accept    = in_valid && in_ready;

  always_comb begin
    case (in_func)
      OP_CLEAR:  kind_in = CMD_CLEAR;
      OP_INSERT: kind_in = (size_used == '0) ? CMD_NONE : CMD_INSERT;
      OP_QUERY:  kind_in = (size_used == '0) ? CMD_NONE : CMD_QUERY;
      default:   kind_in = CMD_NONE;
    endcase
  end

  assign start = accept && (kind_in == CMD_INSERT || kind_in == CMD_QUERY);

  thbf_mod u_mod_a (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (in_hash_low),
    .divisor  (size_used),
    .busy     (busy_a),
    .done     (done_a),
    .rem      (rem_a)
  );

  thbf_mod u_mod_b (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (in_hash_high),
    .divisor  (size_used),
    .busy     (busy_b),
    .done     (done_b),
    .rem      (rem_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= start ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          if (done_a && done_b) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!queue_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= kind_in;
      pos_a <= '0;
      pos_b <= '0;
    end else if (state == F_DIV && done_a && done_b) begin
      pos_a <= rem_a;
      pos_b <= rem_b;
    end
  end

  assign push           = (state == F_PUSH) && !queue_full;
  assign push_cmd.kind  = kind;
  assign push_cmd.pos_a = pos_a;
  assign push_cmd.pos_b = pos_b;

`ifndef SYNTHESIS
  a_dividers_lockstep: assert property (@(posedge clk) disable iff (rst)
    busy_a == busy_b)
    else $error("hash dividers out of step");
`endif

endmodule

`default_nettype wire

FILE: sv/thbf_fifo.sv
`default_nettype none

module thbf_fifo
  import thbf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd,
  output cmd_t      rd_data,
  output logic      empty
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wr_ptr] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && full && !rd) && !(rd && empty))
    else $error("queue overflow or underflow");
`endif

endmodule

`default_nettype wire

FILE: sv/thbf_back.sv
`default_nettype none

module thbf_back
  import thbf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic queue_empty,
  input  wire cmd_t queue_cmd,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      out_present
);

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_RD_A  = 6'b000010,
    B_UPD_A = 6'b000100,
    B_RD_B  = 6'b001000,
    B_UPD_B = 6'b010000,
    B_DONE  = 6'b100000
  } back_state_t;

  back_state_t       state;
  cmd_t              cmd;
  logic [ROWS-1:0]   row_valid;
  logic [COLS-1:0]   mem [ROWS];
  logic [COLS-1:0]   rdata;
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [COLS-1:0]   row_data;
  logic              wr_en;
  logic              hit_a;
  logic              hit_b;
  logic              out_free;

  assign pop      = (state == B_IDLE) && !queue_empty;
  assign out_free = !out_valid || out_ready;

  assign rd_row  = (state == B_RD_A) ? cmd.pos_a[POS_W-1:COL_W] : cmd.pos_b[POS_W-1:COL_W];
  assign cur_row = (state == B_UPD_A) ? cmd.pos_a[POS_W-1:COL_W] : cmd.pos_b[POS_W-1:COL_W];
  assign cur_col = (state == B_UPD_A) ? cmd.pos_a[COL_W-1:0] : cmd.pos_b[COL_W-1:0];

  assign row_data = row_valid[cur_row] ? rdata : '0;
  assign wr_en    = (cmd.kind == CMD_INSERT) && (state == B_UPD_A || state == B_UPD_B);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur_row] <= row_data | (COLS'(1) << cur_col);
    end
    rdata <= mem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            if (queue_cmd.kind == CMD_CLEAR) begin
              row_valid <= '0;
            end
            if (queue_cmd.kind == CMD_INSERT || queue_cmd.kind == CMD_QUERY) begin
              state <= B_RD_A;
            end else begin
              state <= B_DONE;
            end
          end
        end
        B_RD_A:  state <= B_UPD_A;
        B_UPD_A: begin
          if (wr_en) begin
            row_valid[cur_row] <= 1'b1;
          end
          state <= B_RD_B;
        end
        B_RD_B:  state <= B_UPD_B;
        B_UPD_B: begin
          if (wr_en) begin
            row_valid[cur_row] <= 1'b1;
          end
          state <= B_DONE;
        end
        B_DONE: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= queue_cmd;
    end
    if (state == B_UPD_A) begin
      hit_a <= row_data[cur_col];
    end
    if (state == B_UPD_B) begin
      hit_b <= row_data[cur_col];
    end
    if (state == B_DONE && out_free) begin
      out_present <= (cmd.kind == CMD_QUERY) && hit_a && hit_b;
    end
  end

`ifndef SYNTHESIS
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (pop && queue_cmd.kind == CMD_CLEAR) |=> (row_valid == '0))
    else $error("clear left rows marked");
`endif

endmodule

`default_nettype wire

FILE: sv/two_hash_bloom_filter.sv
`default_nettype none

// channel   dir  handshake          payload (low bit up)
// s_        in   s_tvalid/s_tready  s_tdata: hash_low, hash_high; s_tuser: func
// m_        out  m_tvalid/m_tready  m_tdata: present
// cfg_      in   cfg_wr_en          cfg_wr_data: size
//
// Insert and query run two 64-step dividers side by side, then read each position's row
// of the 256 x 256 mark memory in turn, writing it back for insert only.
// Clear drops the per-row valid flags at once.
// Reset is synchronous; the size register returns to 65536 and all marks read zero.
// A stalled m_tready holds the result; the queue lets the next word divide.

module two_hash_bloom_filter
  import thbf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // hash_low, hash_high
  input  wire logic [S_TUSER_W-1:0] s_tuser,   // func, zero pad
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,   // present, zero pad
  input  wire logic                 cfg_wr_en,
  input  wire logic [SIZE_W-1:0]    cfg_wr_data
);

  logic [SIZE_W-1:0] size_cfg;
  logic              push;
  cmd_t              push_cmd;
  logic              queue_full;
  logic              pop;
  cmd_t              queue_cmd;
  logic              queue_empty;
  logic              present;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_cfg <= cfg_wr_data;
    end
  end

  thbf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_func      (s_tuser[FUNC_W-1:0]),
    .in_hash_low  (s_tdata[HASH_W-1:0]),
    .in_hash_high (s_tdata[2*HASH_W-1:HASH_W]),
    .size_cfg     (size_cfg),
    .push         (push),
    .push_cmd     (push_cmd),
    .queue_full   (queue_full)
  );

  thbf_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (push_cmd),
    .full    (queue_full),
    .rd      (pop),
    .rd_data (queue_cmd),
    .empty   (queue_empty)
  );

  thbf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_cmd   (queue_cmd),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_present (present)
  );

  assign m_tdata = {(M_TDATA_W-1)'(0), present};

endmodule

`default_nettype wire

FILE: dv/thbf_checker.sv
`default_nettype none

module thbf_checker
  import thbf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // hash_low, hash_high
  input  wire logic [S_TUSER_W-1:0] s_tuser,   // func, zero pad
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  input  wire logic [M_TDATA_W-1:0] m_tdata,   // present, zero pad
  input  wire logic                 cfg_wr_en,
  input  wire logic [SIZE_W-1:0]    cfg_wr_data,
  output int                        mismatches,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POSITIONS = 1 << POS_W;

  bit                   marks [POSITIONS];
  logic [SIZE_W-1:0]    size_cfg = SIZE_RESET;
  logic [M_TDATA_W-1:0] present_q [$];

  function automatic void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // apply one operation to the mark store and return the membership answer
  function automatic logic filter_answer(logic [FUNC_W-1:0] func,
                                         logic [HASH_W-1:0] hash_low,
                                         logic [HASH_W-1:0] hash_high);
    logic [SIZE_W-1:0] span;
    logic [POS_W-1:0]  pos_a;
    logic [POS_W-1:0]  pos_b;
    logic              hit;
    span  = (size_cfg > SIZE_MAX) ? SIZE_MAX : size_cfg;
    pos_a = '0;
    pos_b = '0;
    hit   = 1'b0;
    if (span != '0) begin
      pos_a = POS_W'(hash_low % HASH_W'(span));
      pos_b = POS_W'(hash_high % HASH_W'(span));
    end
    case (func)
      OP_CLEAR: begin
        marks = '{default: 1'b0};
      end
      OP_INSERT: begin
        if (span != '0) begin
          marks[pos_a] = 1'b1;
          marks[pos_b] = 1'b1;
        end
      end
      OP_QUERY: begin
        hit = (span != '0) && marks[pos_a] && marks[pos_b];
      end
      default: ;
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin
    logic [M_TDATA_W-1:0] want;
    if (rst) begin
      marks = '{default: 1'b0};
      size_cfg = SIZE_RESET;
      present_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (present_q.size() == 0) begin
          flag($sformatf("result word 0x%0h with no word outstanding", m_tdata));
        end else begin
          want = present_q.pop_front();
          if (m_tdata !== want)
            flag($sformatf("present mismatch: expected 0x%0h, got 0x%0h", want, m_tdata));
        end
      end
      if (s_tvalid && s_tready)
        present_q.insert(present_q.size(),
                         M_TDATA_W'(filter_answer(s_tuser[FUNC_W-1:0],
                                                  s_tdata[HASH_W-1:0],
                                                  s_tdata[S_TDATA_W-1:HASH_W])));
      if (cfg_wr_en) size_cfg = cfg_wr_data;
    end
    pending <= present_q.size();
  end

endmodule

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import thbf_pkg::*;

  localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [HASH_W-1:0] ALL_ONES  = '1;
  localparam logic [HASH_W-1:0] TOP_BIT   = 64'h8000_0000_0000_0000;
  localparam int                PHASES    = 10;
  localparam int                PHASE_LEN = 118;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0]    cfg_wr_data = '0;
  logic                 steady = 1'b0;
  int                   mismatches;
  int                   pending;
  logic [HASH_W-1:0]    kept_low [$];
  logic [HASH_W-1:0]    kept_high [$];
  logic [SIZE_W-1:0]    sizes [PHASES];

  always #5 clk = ~clk;

  two_hash_bloom_filter u_dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  thbf_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 8);
  end

  task automatic push_word(logic [FUNC_W-1:0] func, logic [HASH_W-1:0] hash_low,
                           logic [HASH_W-1:0] hash_high);
    while (!steady && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {hash_high, hash_low};
    s_tuser  <= S_TUSER_W'(func);
    do @(posedge clk); while (!s_tready);
  endtask

  // hold off the sender until every outstanding word has answered
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [HASH_W-1:0] pick_hash();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return HASH_W'($urandom_range(200));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_word();
    int                pick;
    int                idx;
    logic [HASH_W-1:0] hash_low;
    logic [HASH_W-1:0] hash_high;
    pick      = $urandom_range(99);
    hash_low  = pick_hash();
    hash_high = pick_hash();
    if (pick < 2) begin
      push_word(OP_CLEAR, hash_low, hash_high);
    end else if (pick < 4) begin
      push_word(OP_UNUSED, hash_low, hash_high);
    end else if (pick < 50) begin
      push_word(OP_INSERT, hash_low, hash_high);
      kept_low.insert(kept_low.size(), hash_low);
      kept_high.insert(kept_high.size(), hash_high);
      if (kept_low.size() > 64) begin
        void'(kept_low.pop_front());
        void'(kept_high.pop_front());
      end
    end else begin
      // revisit an inserted hash most of the time, sometimes with one word changed
      if (kept_low.size() != 0 && $urandom_range(3) != 0) begin
        idx = $urandom_range(kept_low.size() - 1);
        case ($urandom_range(5))
          0:       hash_low = kept_low[idx];
          1:       hash_high = kept_high[idx];
          default: begin
            hash_low  = kept_low[idx];
            hash_high = kept_high[idx];
          end
        endcase
      end
      push_word(OP_QUERY, hash_low, hash_high);
    end
  endtask

  initial begin
    sizes = '{SIZE_RESET, 17'd10, 17'd1, 17'd0, 17'h1FFFF, 17'h10001, 17'd1000, 17'd3,
              SIZE_W'($urandom_range(40, 2)), SIZE_W'($urandom_range(131071))};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_word(OP_QUERY, '0, '0);
    push_word(OP_INSERT, '0, ALL_ONES);
    push_word(OP_QUERY, '0, ALL_ONES);
    push_word(OP_QUERY, ALL_ONES, '0);
    push_word(OP_QUERY, '0, 64'd1);
    push_word(OP_INSERT, 64'h5, 64'h10005);
    push_word(OP_QUERY, 64'h5, 64'h5);
    push_word(OP_UNUSED, ALL_ONES, ALL_ONES);
    push_word(OP_QUERY, 64'd1, 64'd1);
    push_word(OP_CLEAR, ALL_ONES, ALL_ONES);
    push_word(OP_QUERY, '0, ALL_ONES);
    push_word(OP_INSERT, TOP_BIT, ~TOP_BIT);
    push_word(OP_QUERY, TOP_BIT, ~TOP_BIT);
    write_size('0);
    push_word(OP_INSERT, 64'd3, 64'd4);
    push_word(OP_QUERY, 64'd3, 64'd4);
    push_word(OP_QUERY, TOP_BIT, ~TOP_BIT);
    write_size(17'h10001);
    push_word(OP_QUERY, TOP_BIT, ~TOP_BIT);
    write_size(17'd1);
    push_word(OP_QUERY, 64'd9, ALL_ONES);
    push_word(OP_INSERT, 64'd9, 64'd10);

    for (int p = 0; p < PHASES; p++) begin
      write_size(sizes[p]);
      steady <= (p == 5);
      for (int n = 0; n < PHASE_LEN; n++) begin
        random_word();
        if ($urandom_range(59) == 0) drain();
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
